// ===== hw/rtl/phc_pkg.sv =====
// Shared types and constants of the polygon half-plane clip unit.
`default_nettype none
package phc_pkg;
	typedef enum logic [1:0] {
		PH_START = 2'd0,
		PH_IN    = 2'd1,
		PH_OUT   = 2'd2,
		PH_UNUSED = 2'd3
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SIDE_A,
		ST_SIDE_B,
		ST_DECIDE,
		ST_IC_SETUP,
		ST_IC_SIDE_B,
		ST_IC_PREP,
		ST_DIV,
		ST_LERP_X,
		ST_LERP_Y,
		ST_EMIT,
		ST_WAIT
	} state_t;

	typedef enum logic [1:0] {
		EM_NONE   = 2'd0,
		EM_VERTEX = 2'd1,
		EM_IC     = 2'd2,
		EM_MARKER = 2'd3
	} emit_t;

	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_START_Y = 2'd1;
	localparam logic [1:0] REG_END_X   = 2'd2;
	localparam logic [1:0] REG_END_Y   = 2'd3;

	typedef struct packed {
		logic start;
		logic busy;
		logic done;
	} div_ctrl_t;
endpackage
`default_nettype wire

// ===== hw/rtl/phc_if.sv =====
// Valid/ready stream interfaces for vertex and result words.
`default_nettype none
interface phc_vertex_if #(parameter int CW = 32);
	logic valid;
	logic ready;
	logic signed [CW-1:0] in_x;
	logic signed [CW-1:0] in_y;
	logic is_last;
	modport source (output valid, in_x, in_y, is_last, input ready);
	modport sink (input valid, in_x, in_y, is_last, output ready);
endinterface

interface phc_result_if #(parameter int CW = 32);
	logic valid;
	logic ready;
	logic signed [CW-1:0] out_x;
	logic signed [CW-1:0] out_y;
	logic has_point;
	logic end_of_polygon;
	modport source (output valid, out_x, out_y, has_point, end_of_polygon, input ready);
	modport sink (input valid, out_x, out_y, has_point, end_of_polygon, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/phc_div.sv =====
// Serial restoring divider producing a FRAC_BITS-bit fraction, one bit per cycle.
`default_nettype none
module phc_div #(
	parameter int W = 66,
	parameter int FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic [W-1:0] num,
	input  wire logic [W-1:0] den,
	output phc_pkg::div_ctrl_t ctrl,
	output logic [FRAC_BITS:0] quot
);
	localparam int CNT_W = $clog2(FRAC_BITS + 2);
	logic [W:0] rem_q;
	logic [W-1:0] den_q;
	logic [FRAC_BITS:0] quot_q;
	logic [CNT_W-1:0] cnt_q;
	logic busy_q, done_q;
	logic [W:0] shl;

	assign shl = {rem_q[W-1:0], 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (den == '0 || num >= den) begin
					done_q <= 1'b1;
				end else if (FRAC_BITS == 0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q <= CNT_W'(FRAC_BITS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, num};
			den_q <= den;
			if (den == '0) quot_q <= '0;
			else if (num >= den) quot_q <= (FRAC_BITS+1)'(1) << FRAC_BITS;
			else quot_q <= '0;
		end else if (busy_q) begin
			if (shl >= {1'b0, den_q}) begin
				rem_q <= shl - {1'b0, den_q};
				quot_q <= {quot_q[FRAC_BITS-1:0], 1'b1};
			end else begin
				rem_q <= shl;
				quot_q <= {quot_q[FRAC_BITS-1:0], 1'b0};
			end
		end
	end

	assign ctrl.start = start;
	assign ctrl.busy = busy_q;
	assign ctrl.done = done_q;
	assign quot = quot_q;

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		!(busy_q && done_q)) else $error("divider busy and done together");
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start) else $error("divider restarted while busy");
	a_frac: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && FRAC_BITS > 0) |-> !quot_q[FRAC_BITS]) else $error("fraction overflow");
endmodule
`default_nettype wire

// ===== hw/rtl/polygon_halfplane_clip_unit.sv =====
// Top level of the polygon half-plane clip unit.
`default_nettype none
// Clips a streamed polygon against the half-plane to the right of a directed edge
// (points on the edge count as inside), one Sutherland-Hodgman stage. Vertex words
// enter one at a time; the block is busy until all result words of that vertex have
// been handed over. Each intercept runs through setup, the serial restoring divider
// and lerp; the divider is the unit that sets the rate, and a last vertex may emit
// two intercepts. Each side value is formed by one shared signed multiplier used for
// both products in turn, the first product registered. The output word sits in a
// register, so the sink may stall freely; the block waits until it is taken.
// Configuration writes are only meant to happen while the block is idle.
module polygon_halfplane_clip_unit #(
	parameter int COORD_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [COORD_WIDTH-1:0] cfg_data,
	phc_vertex_if.sink vin,
	phc_result_if.source rout
);
	localparam int CW = COORD_WIDTH;
	localparam int DW = CW + 1;        // difference width
	localparam int PW = 2 * DW;        // product width
	localparam int SW = PW + 1;        // side value width
	localparam int LW = DW + FRAC_BITS + 1;

	// Edge registers.
	logic signed [CW-1:0] sx_q, sy_q, ex_q, ey_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= '0; sy_q <= '0; ex_q <= '0; ey_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				phc_pkg::REG_START_X: sx_q <= cfg_data;
				phc_pkg::REG_START_Y: sy_q <= cfg_data;
				phc_pkg::REG_END_X:   ex_q <= cfg_data;
				phc_pkg::REG_END_Y:   ey_q <= cfg_data;
				default: ;
			endcase
		end
	end

	phc_pkg::state_t state_q, state_d;
	phc_pkg::phase_t phase_q;
	logic first_in_q;
	logic signed [CW-1:0] fx_q, fy_q, px_q, py_q, vx_q, vy_q;
	logic last_q, inside_q;
	// Intercept operands: old point O and new point N.
	logic signed [CW-1:0] ox_q, oy_q, nx_q, ny_q;
	logic signed [SW-1:0] so_q, prod_q;
	// Emission plan for this vertex, in order.
	phc_pkg::emit_t plan_q [3];
	phc_pkg::emit_t plan_d [3];
	logic [1:0] idx_q;
	logic [1:0] cnt_q, cnt_d;
	// Set when the last planned word is the closing intercept towards the first vertex.
	logic close_q, close_d;
	logic signed [CW-1:0] ix_q, iy_q;
	logic [FRAC_BITS:0] quot;
	phc_pkg::div_ctrl_t dctl;
	logic div_start;
	logic [SW-1:0] num_q, den_q;
	logic side_second_q;
	// Previous vertex as it was before this vertex, kept for the intercept.
	logic signed [CW-1:0] pxo_q, pyo_q;

	// Shared multiplier: operands chosen by which point and which half.
	logic signed [CW-1:0] mpx, mpy;
	logic signed [DW-1:0] ma, mb;
	logic signed [PW-1:0] mprod;
	always_comb begin
		mpx = vx_q; mpy = vy_q;
		if (state_q == phc_pkg::ST_IC_SETUP) begin
			mpx = ox_q; mpy = oy_q;
		end else if (state_q == phc_pkg::ST_IC_SIDE_B) begin
			mpx = nx_q; mpy = ny_q;
		end
		if (!side_second_q) begin
			ma = DW'(mpx) - DW'(sx_q);
			mb = DW'(ey_q) - DW'(sy_q);
		end else begin
			ma = DW'(mpy) - DW'(sy_q);
			mb = DW'(ex_q) - DW'(sx_q);
		end
		mprod = ma * mb;
	end

	// Lerp step: delta magnitude times fraction.
	logic signed [DW-1:0] dlt;
	logic [DW-1:0] dmag;
	logic [LW-1:0] lprod;
	logic [LW-1:0] lsh;
	logic signed [CW-1:0] lres;
	always_comb begin
		if (state_q == phc_pkg::ST_LERP_X) dlt = DW'(nx_q) - DW'(ox_q);
		else dlt = DW'(ny_q) - DW'(oy_q);
		dmag = dlt[DW-1] ? DW'(-dlt) : DW'(dlt);
		lprod = LW'(dmag) * LW'(quot);
		lsh = lprod >> FRAC_BITS;
		if (state_q == phc_pkg::ST_LERP_X)
			lres = dlt[DW-1] ? CW'(ox_q - CW'(lsh)) : CW'(ox_q + CW'(lsh));
		else
			lres = dlt[DW-1] ? CW'(oy_q - CW'(lsh)) : CW'(oy_q + CW'(lsh));
	end

	logic signed [SW-1:0] side_full, diff, dmg;
	assign side_full = prod_q - SW'(mprod);
	assign diff = so_q - side_full;
	assign dmg = diff[SW-1] ? -diff : diff;

	phc_div #(.W(SW), .FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(num_q), .den(den_q), .ctrl(dctl), .quot(quot));

	logic out_valid_q;
	logic out_taken;
	assign out_taken = out_valid_q && rout.ready;
	phc_pkg::emit_t cur;
	assign cur = plan_q[idx_q];

	// Emission plan of the current vertex. The closing intercept only exists when the
	// polygon has a recorded first vertex and this last vertex lies on the other side.
	always_comb begin
		plan_d[0] = phc_pkg::EM_NONE;
		plan_d[1] = phc_pkg::EM_NONE;
		plan_d[2] = phc_pkg::EM_NONE;
		cnt_d = 2'd0;
		close_d = 1'b0;
		if (phase_q == phc_pkg::PH_IN) begin
			plan_d[0] = inside_q ? phc_pkg::EM_VERTEX : phc_pkg::EM_IC;
			cnt_d = 2'd1;
		end else if (phase_q == phc_pkg::PH_OUT) begin
			if (inside_q) begin
				plan_d[0] = phc_pkg::EM_IC;
				plan_d[1] = phc_pkg::EM_VERTEX;
				cnt_d = 2'd2;
			end
		end else if (inside_q) begin
			plan_d[0] = phc_pkg::EM_VERTEX;
			cnt_d = 2'd1;
		end
		if (last_q) begin
			if (phase_q inside {phc_pkg::PH_IN, phc_pkg::PH_OUT} &&
					inside_q != first_in_q) begin
				plan_d[cnt_d] = phc_pkg::EM_IC;
				cnt_d = cnt_d + 2'd1;
				close_d = 1'b1;
			end
			if (cnt_d == 2'd0) begin
				plan_d[0] = phc_pkg::EM_MARKER;
				cnt_d = 2'd1;
			end
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			phc_pkg::ST_IDLE: if (vin.valid) state_d = phc_pkg::ST_SIDE_A;
			phc_pkg::ST_SIDE_A: state_d = phc_pkg::ST_SIDE_B;
			phc_pkg::ST_SIDE_B: state_d = phc_pkg::ST_DECIDE;
			phc_pkg::ST_DECIDE: state_d = phc_pkg::ST_EMIT;
			phc_pkg::ST_EMIT: begin
				if (idx_q == cnt_q) state_d = phc_pkg::ST_IDLE;
				else if (cur == phc_pkg::EM_IC) state_d = phc_pkg::ST_IC_SETUP;
				else state_d = phc_pkg::ST_WAIT;
			end
			phc_pkg::ST_IC_SETUP: if (side_second_q) state_d = phc_pkg::ST_IC_SIDE_B;
			phc_pkg::ST_IC_SIDE_B: if (side_second_q) state_d = phc_pkg::ST_IC_PREP;
			phc_pkg::ST_IC_PREP: state_d = phc_pkg::ST_DIV;
			phc_pkg::ST_DIV: if (dctl.done) state_d = phc_pkg::ST_LERP_X;
			phc_pkg::ST_LERP_X: state_d = phc_pkg::ST_LERP_Y;
			phc_pkg::ST_LERP_Y: state_d = phc_pkg::ST_WAIT;
			phc_pkg::ST_WAIT: if (out_taken) state_d = phc_pkg::ST_EMIT;
			default: state_d = phc_pkg::ST_IDLE;
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		vin.ready = (state_q == phc_pkg::ST_IDLE);
		div_start = (state_q == phc_pkg::ST_IC_PREP);
	end

	logic ins_now;
	assign ins_now = !side_full[SW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= phc_pkg::ST_IDLE;
			phase_q <= phc_pkg::PH_START;
			first_in_q <= 1'b0;
			fx_q <= '0; fy_q <= '0; px_q <= '0; py_q <= '0;
			idx_q <= '0; cnt_q <= '0;
			plan_q <= '{phc_pkg::EM_NONE, phc_pkg::EM_NONE, phc_pkg::EM_NONE};
			close_q <= 1'b0;
			side_second_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_taken) out_valid_q <= 1'b0;
			case (state_q)
				phc_pkg::ST_SIDE_A: side_second_q <= 1'b1;
				phc_pkg::ST_SIDE_B: side_second_q <= 1'b0;
				phc_pkg::ST_IC_SETUP, phc_pkg::ST_IC_SIDE_B:
					side_second_q <= !side_second_q;
				phc_pkg::ST_DECIDE: begin
					idx_q <= '0;
					plan_q <= plan_d;
					cnt_q <= cnt_d;
					close_q <= close_d;
					if (!(phase_q inside {phc_pkg::PH_IN, phc_pkg::PH_OUT})) begin
						fx_q <= vx_q; fy_q <= vy_q;
						first_in_q <= inside_q;
					end
					if (last_q) phase_q <= phc_pkg::PH_START;
					else phase_q <= inside_q ? phc_pkg::PH_IN : phc_pkg::PH_OUT;
					px_q <= vx_q; py_q <= vy_q;
				end
				phc_pkg::ST_LERP_Y: out_valid_q <= 1'b1;
				phc_pkg::ST_EMIT: begin
					if (idx_q != cnt_q && cur != phc_pkg::EM_IC) out_valid_q <= 1'b1;
				end
				phc_pkg::ST_WAIT: if (out_taken) idx_q <= idx_q + 2'd1;
				default: ;
			endcase
		end
	end

	// Data path registers.
	always_ff @(posedge clk) begin
		case (state_q)
			phc_pkg::ST_IDLE: begin
				vx_q <= vin.in_x; vy_q <= vin.in_y; last_q <= vin.is_last;
			end
			phc_pkg::ST_SIDE_A: prod_q <= SW'(mprod);
			phc_pkg::ST_SIDE_B: inside_q <= ins_now;
			phc_pkg::ST_EMIT: begin
				// The closing intercept runs from the last vertex towards the first;
				// every other intercept runs from the previous vertex to this one.
				if (close_q && idx_q == cnt_q - 2'd1) begin
					ox_q <= vx_q; oy_q <= vy_q; nx_q <= fx_q; ny_q <= fy_q;
				end else begin
					ox_q <= pxo_q; oy_q <= pyo_q; nx_q <= vx_q; ny_q <= vy_q;
				end
			end
			phc_pkg::ST_IC_SETUP: begin
				if (!side_second_q) prod_q <= SW'(mprod);
				else so_q <= side_full;
			end
			phc_pkg::ST_IC_SIDE_B: begin
				if (!side_second_q) prod_q <= SW'(mprod);
				else begin
					num_q <= so_q[SW-1] ? SW'(-so_q) : SW'(so_q);
					den_q <= dmg;
				end
			end
			phc_pkg::ST_LERP_X: ix_q <= lres;
			phc_pkg::ST_LERP_Y: iy_q <= lres;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == phc_pkg::ST_SIDE_A) begin
			pxo_q <= px_q; pyo_q <= py_q;
		end
	end

	// Result word fields.
	logic emitting_ic_q;
	always_ff @(posedge clk) begin
		if (state_q == phc_pkg::ST_EMIT) emitting_ic_q <= (cur == phc_pkg::EM_IC);
	end
	always_comb begin
		rout.valid = out_valid_q;
		rout.end_of_polygon = last_q && (idx_q == cnt_q - 2'd1);
		if (emitting_ic_q) begin
			rout.out_x = ix_q; rout.out_y = iy_q; rout.has_point = 1'b1;
		end else if (plan_q[idx_q] == phc_pkg::EM_MARKER) begin
			rout.out_x = '0; rout.out_y = '0; rout.has_point = 1'b0;
		end else begin
			rout.out_x = vx_q; rout.out_y = vy_q; rout.has_point = 1'b1;
		end
	end

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		vin.ready |-> !out_valid_q) else $error("ready while a word is pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !rout.ready) |=> out_valid_q) else $error("result word dropped");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= cnt_q) else $error("emit index beyond plan");
	a_div: assert property (@(posedge clk) disable iff (!arst_n)
		dctl.busy |-> state_q == phc_pkg::ST_DIV) else $error("divider busy outside divide");
endmodule
`default_nettype wire
